### hw/rtl/gda_pkg.sv
// Shared constants and month table for the Gregorian date add-days unit.
`timescale 1ns / 1ps
`default_nettype none

package gda_pkg;

  localparam int unsigned NUM_STAGES = 17;

  localparam logic [14:0] YEAR_BIAS    = 15'd400;
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;

  localparam logic [15:0] RECIP_400  = 16'((64'd1 << 24) / 64'd400);
  localparam logic [22:0] RECIP_ERA  = 23'((64'd1 << 40) / 64'd146097);
  localparam logic [17:0] RECIP_1460 = 18'((64'd1 << 28) / 64'd1460);
  localparam logic [18:0] RECIP_365  = 19'((64'd1 << 27) / 64'd365);

  // first and last supported day: 1600-01-01 and 9999-12-31 on a 400-year bias
  localparam logic [21:0] SERIAL_LO = 22'd730425;
  localparam logic [21:0] SERIAL_HI = 22'd3798461;

  // day of a March-based year on which month index mp starts
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/gda_date2serial.sv
// Date to day serial pipeline: month folding, era split and offset add.
`timescale 1ns / 1ps
`default_nettype none

module gda_date2serial
  import gda_pkg::*;
(
  input  logic               clk,
  input  logic [4:0]         adv,
  input  logic [13:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic signed [20:0] day_offset,
  output logic signed [23:0] serial
);

  logic [3:0]         m0;
  logic [3:0]         mp;
  logic               fold_dn;
  logic               fold_up;
  logic               jan_feb;
  logic [14:0]        yb_nxt;
  logic signed [23:0] dayoff_nxt;

  logic [14:0]        yb1_r;
  logic [8:0]         doy1_r;
  logic signed [23:0] dayoff1_r;

  logic [30:0]        p400;
  logic [5:0]         era2_r;
  logic [14:0]        yb2_r;
  logic [8:0]         doy2_r;
  logic signed [23:0] dayoff2_r;

  logic [14:0]        rem3;
  logic [5:0]         era3_r;
  logic [8:0]         yoe3_r;
  logic [8:0]         doy3_r;
  logic signed [23:0] dayoff3_r;

  logic [1:0]         cent4;
  logic [22:0]        base4_r;
  logic [17:0]        doe4_r;
  logic signed [23:0] dayoff4_r;

  logic signed [23:0] z5_r;

  // fold month into year, March-based month index
  always_comb begin
    fold_dn = 1'b0;
    fold_up = 1'b0;
    m0      = month - 4'd1;
    if (month == 4'd0) begin
      m0      = 4'd11;
      fold_dn = 1'b1;
    end else if (month >= 4'd13) begin
      m0      = month - 4'd13;
      fold_up = 1'b1;
    end
    jan_feb    = (m0 <= 4'd1);
    mp         = (m0 >= 4'd2) ? m0 - 4'd2 : m0 + 4'd10;
    yb_nxt     = {1'b0, year} + YEAR_BIAS + {14'd0, fold_up} - {14'd0, fold_dn}
                 - {14'd0, jan_feb};
    dayoff_nxt = $signed({19'd0, day}) - 24'sd1
                 + $signed({{3{day_offset[20]}}, day_offset});
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      yb1_r     <= yb_nxt;
      doy1_r    <= month_start(mp);
      dayoff1_r <= dayoff_nxt;
    end
  end

  assign p400 = {16'd0, yb1_r} * {15'd0, RECIP_400};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      era2_r    <= p400[29:24];
      yb2_r     <= yb1_r;
      doy2_r    <= doy1_r;
      dayoff2_r <= dayoff1_r;
    end
  end

  assign rem3 = yb2_r - {9'd0, era2_r} * 15'd400;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      if (rem3 >= 15'd400) begin
        era3_r <= era2_r + 6'd1;
        yoe3_r <= 9'(rem3 - 15'd400);
      end else begin
        era3_r <= era2_r;
        yoe3_r <= rem3[8:0];
      end
      doy3_r    <= doy2_r;
      dayoff3_r <= dayoff2_r;
    end
  end

  always_comb begin
    if (yoe3_r >= 9'd300) begin
      cent4 = 2'd3;
    end else if (yoe3_r >= 9'd200) begin
      cent4 = 2'd2;
    end else if (yoe3_r >= 9'd100) begin
      cent4 = 2'd1;
    end else begin
      cent4 = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      base4_r   <= {17'd0, era3_r} * {5'd0, DAYS_PER_ERA};
      doe4_r    <= {9'd0, yoe3_r} * 18'd365 + {11'd0, yoe3_r[8:2]} - {16'd0, cent4}
                   + {9'd0, doy3_r};
      dayoff4_r <= dayoff3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      z5_r <= $signed({1'b0, base4_r}) + $signed({6'd0, doe4_r}) + dayoff4_r;
    end
  end

  assign serial = z5_r;

endmodule

`default_nettype wire

### hw/rtl/gda_serial2date.sv
// Day serial to date pipeline: range clamp, era and year split, month lookup.
`timescale 1ns / 1ps
`default_nettype none

module gda_serial2date
  import gda_pkg::*;
(
  input  logic               clk,
  input  logic [11:0]        adv,
  input  logic signed [23:0] serial,
  output logic [13:0]        result_year,
  output logic [3:0]         result_month,
  output logic [4:0]         result_day,
  output logic               range_error
);

  logic [21:0] zc6_r;
  logic        err6_r;

  logic [44:0] p_era;
  logic [4:0]  era7_r;
  logic [21:0] zc7_r;
  logic        err7_r;

  logic [22:0] prod8;
  logic [21:0] prod8_r;
  logic [4:0]  era8_r;
  logic [21:0] zc8_r;
  logic        err8_r;

  logic [21:0] diff9;
  logic [4:0]  era9_r;
  logic [17:0] doe9_r;
  logic        err9_r;

  logic [35:0] p1460;
  logic [2:0]  q36524;
  logic [6:0]  q1460_10_r;
  logic [2:0]  q36524_10_r;
  logic        qlast10_r;
  logic [4:0]  era10_r;
  logic [17:0] doe10_r;
  logic        err10_r;

  logic [17:0] rem11;
  logic [6:0]  q1460_11_r;
  logic [2:0]  q36524_11_r;
  logic        qlast11_r;
  logic [4:0]  era11_r;
  logic [17:0] doe11_r;
  logic        err11_r;

  logic [17:0] t12_r;
  logic [4:0]  era12_r;
  logic [17:0] doe12_r;
  logic        err12_r;

  logic [36:0] p365;
  logic [8:0]  yoe13_r;
  logic [17:0] t13_r;
  logic [4:0]  era13_r;
  logic [17:0] doe13_r;
  logic        err13_r;

  logic [17:0] rem14;
  logic [8:0]  yoe14_r;
  logic [4:0]  era14_r;
  logic [17:0] doe14_r;
  logic        err14_r;

  logic [1:0]  cent15;
  logic [17:0] yday15;
  logic [8:0]  doy15_r;
  logic [8:0]  yoe15_r;
  logic [4:0]  era15_r;
  logic        err15_r;

  logic [3:0]  mp16;
  logic [3:0]  mp16_r;
  logic [8:0]  doy16_r;
  logic [8:0]  yoe16_r;
  logic [4:0]  era16_r;
  logic        err16_r;

  logic [3:0]  mm17;
  logic        jan_feb17;
  logic [14:0] year17;
  logic [8:0]  dd17;

  logic [13:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic        err_r;

  // clamp to the supported range
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      if (serial < $signed({2'b00, SERIAL_LO})) begin
        zc6_r  <= SERIAL_LO;
        err6_r <= 1'b1;
      end else if (serial > $signed({2'b00, SERIAL_HI})) begin
        zc6_r  <= SERIAL_HI;
        err6_r <= 1'b1;
      end else begin
        zc6_r  <= serial[21:0];
        err6_r <= 1'b0;
      end
    end
  end

  assign p_era = {23'd0, zc6_r} * {22'd0, RECIP_ERA};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      era7_r <= p_era[44:40];
      zc7_r  <= zc6_r;
      err7_r <= err6_r;
    end
  end

  assign prod8 = {18'd0, era7_r} * {5'd0, DAYS_PER_ERA};

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      prod8_r <= prod8[21:0];
      era8_r  <= era7_r;
      zc8_r   <= zc7_r;
      err8_r  <= err7_r;
    end
  end

  assign diff9 = zc8_r - prod8_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      if (diff9 >= {4'd0, DAYS_PER_ERA}) begin
        era9_r <= era8_r + 5'd1;
        doe9_r <= 18'(diff9 - {4'd0, DAYS_PER_ERA});
      end else begin
        era9_r <= era8_r;
        doe9_r <= diff9[17:0];
      end
      err9_r <= err8_r;
    end
  end

  assign p1460  = {18'd0, doe9_r} * {18'd0, RECIP_1460};
  assign q36524 = 3'(doe9_r >= 18'd36524) + 3'(doe9_r >= 18'd73048)
                  + 3'(doe9_r >= 18'd109572) + 3'(doe9_r >= 18'd146096);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      q1460_10_r  <= p1460[34:28];
      q36524_10_r <= q36524;
      qlast10_r   <= (doe9_r == 18'd146096);
      era10_r     <= era9_r;
      doe10_r     <= doe9_r;
      err10_r     <= err9_r;
    end
  end

  assign rem11 = doe10_r - {11'd0, q1460_10_r} * 18'd1460;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      q1460_11_r  <= (rem11 >= 18'd1460) ? q1460_10_r + 7'd1 : q1460_10_r;
      q36524_11_r <= q36524_10_r;
      qlast11_r   <= qlast10_r;
      era11_r     <= era10_r;
      doe11_r     <= doe10_r;
      err11_r     <= err10_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      t12_r   <= doe11_r - {11'd0, q1460_11_r} + {15'd0, q36524_11_r}
                 - {17'd0, qlast11_r};
      era12_r <= era11_r;
      doe12_r <= doe11_r;
      err12_r <= err11_r;
    end
  end

  assign p365 = {19'd0, t12_r} * {18'd0, RECIP_365};

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      yoe13_r <= p365[35:27];
      t13_r   <= t12_r;
      era13_r <= era12_r;
      doe13_r <= doe12_r;
      err13_r <= err12_r;
    end
  end

  assign rem14 = t13_r - {9'd0, yoe13_r} * 18'd365;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      yoe14_r <= (rem14 >= 18'd365) ? yoe13_r + 9'd1 : yoe13_r;
      era14_r <= era13_r;
      doe14_r <= doe13_r;
      err14_r <= err13_r;
    end
  end

  always_comb begin
    if (yoe14_r >= 9'd300) begin
      cent15 = 2'd3;
    end else if (yoe14_r >= 9'd200) begin
      cent15 = 2'd2;
    end else if (yoe14_r >= 9'd100) begin
      cent15 = 2'd1;
    end else begin
      cent15 = 2'd0;
    end
    yday15 = {9'd0, yoe14_r} * 18'd365 + {11'd0, yoe14_r[8:2]} - {16'd0, cent15};
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      doy15_r <= 9'(doe14_r - yday15);
      yoe15_r <= yoe14_r;
      era15_r <= era14_r;
      err15_r <= err14_r;
    end
  end

  always_comb begin
    mp16 = 4'd0;
    for (int k = 1; k < 12; k++) begin
      mp16 = mp16 + 4'(month_start(4'(k)) <= doy15_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      mp16_r  <= mp16;
      doy16_r <= doy15_r;
      yoe16_r <= yoe15_r;
      era16_r <= era15_r;
      err16_r <= err15_r;
    end
  end

  always_comb begin
    mm17      = (mp16_r < 4'd10) ? mp16_r + 4'd3 : mp16_r - 4'd9;
    jan_feb17 = (mm17 <= 4'd2);
    dd17      = doy16_r - month_start(mp16_r) + 9'd1;
    year17    = {10'd0, era16_r} * 15'd400 + {6'd0, yoe16_r} + {14'd0, jan_feb17}
                - YEAR_BIAS;
  end

  always_ff @(posedge clk) begin
    if (adv[11]) begin
      year_r  <= year17[13:0];
      month_r <= mm17;
      day_r   <= dd17[4:0];
      err_r   <= err16_r;
    end
  end

  assign result_year  = year_r;
  assign result_month = month_r;
  assign result_day   = day_r;
  assign range_error  = err_r;

endmodule

`default_nettype wire

### hw/rtl/gregorian_date_add_days_unit.sv
// Top level of the Gregorian date add-days unit: stage valids and flow control.
// Throughput: one transfer per cycle while out_stall is low or a stage is empty;
// the 17-stage pipeline is fully overlapped.
// Empty stages collapse under output stall, so input keeps flowing until all are full.
// Reset clears every stage valid bit; the datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_add_days_unit
  import gda_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [13:0]        in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day,
  input  logic signed [20:0] in_day_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [13:0]        out_result_year,
  output logic [3:0]         out_result_month,
  output logic [4:0]         out_result_day,
  output logic               out_range_error
);

  logic [NUM_STAGES:1] valid_r;
  logic [NUM_STAGES:1] valid_nxt;
  logic [NUM_STAGES:1] ld;
  logic signed [23:0]  serial;

  // a stage loads when any stage from it to the output is empty or the output drains
  for (genvar i = 1; i <= NUM_STAGES; i++) begin : g_ld
    assign ld[i] = !out_stall || !(&valid_r[NUM_STAGES:i]);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ld[1]) begin
      valid_nxt[1] = in_valid;
    end
    for (int i = 2; i <= NUM_STAGES; i++) begin
      if (ld[i]) begin
        valid_nxt[i] = valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  gda_date2serial u_d2s (
    .clk        (clk),
    .adv        (ld[5:1]),
    .year       (in_year),
    .month      (in_month),
    .day        (in_day),
    .day_offset (in_day_offset),
    .serial     (serial)
  );

  gda_serial2date u_s2d (
    .clk          (clk),
    .adv          (ld[NUM_STAGES:6]),
    .serial       (serial),
    .result_year  (out_result_year),
    .result_month (out_result_month),
    .result_day   (out_result_day),
    .range_error  (out_range_error)
  );

  assign in_stall  = !ld[1];
  assign out_valid = valid_r[NUM_STAGES];

endmodule

`default_nettype wire

### hw/rtl/gda_checker.sv
// Port-level assertions for the date add-days unit and their bind.
`timescale 1ns / 1ps
`default_nettype none

module gda_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [13:0] out_result_year,
  input logic [3:0]  out_result_month,
  input logic [4:0]  out_result_day,
  input logic        out_range_error
);

  // hold a stalled transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_year)
      && $stable(out_result_month) && $stable(out_result_day)
      && $stable(out_range_error))
    else $error("stalled result changed");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_year >= 14'd1600 && out_result_year <= 14'd9999
      && out_result_month >= 4'd1 && out_result_month <= 4'd12
      && out_result_day >= 5'd1 && out_result_day <= 5'd31)
    else $error("result date out of range");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |->
      (out_result_year == 14'd1600 && out_result_month == 4'd1 && out_result_day == 5'd1)
      || (out_result_year == 14'd9999 && out_result_month == 4'd12
          && out_result_day == 5'd31))
    else $error("range error without clamped date");

  a_month_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_result_month != 4'd4 && out_result_month != 4'd6
        && out_result_month != 4'd9 && out_result_month != 4'd11)
       || out_result_day <= 5'd30)
      && (out_result_month != 4'd2 || out_result_day <= 5'd29))
    else $error("day past end of month");

endmodule

bind gregorian_date_add_days_unit gda_checker u_gda_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_year  (out_result_year),
  .out_result_month (out_result_month),
  .out_result_day   (out_result_day),
  .out_range_error  (out_range_error)
);

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the Gregorian date add-days unit.
`timescale 1ns / 1ps

module tb_top;

  localparam longint YEAR_FLOOR = 1600;
  localparam longint YEAR_CEIL  = 9999;
  localparam longint YEAR_SHIFT = 40000;
  localparam longint ERA_DAYS   = 146097;
  localparam int     HOLD_CYCLES  = 120;
  localparam int     DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        range_error;
  } date_result_t;

  class date_scoreboard;
    date_result_t pending_dates[$];
    int           errors;

    function longint first_day_number(longint y, longint mm);
      longint yy, era, yoe, mp, doy;
      yy  = y - ((mm <= 2) ? 1 : 0);
      era = yy / 400;
      yoe = yy - era * 400;
      mp  = (mm + 9) % 12;
      doy = (153 * mp + 2) / 5;
      return era * ERA_DAYS + yoe * 365 + yoe / 4 - yoe / 100 + doy;
    endfunction

    function date_result_t predict_date(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                                        logic signed [20:0] off);
      longint yb, mi, z, lo, hi, era, doe, yoe, doy, mp, mm, ry;
      date_result_t r;
      yb = longint'(y) + YEAR_SHIFT;
      mi = longint'(m) - 1;
      if (mi < 0) begin
        mi = mi + 12;
        yb = yb - 1;
      end else if (mi >= 12) begin
        mi = mi - 12;
        yb = yb + 1;
      end
      z  = first_day_number(yb, mi + 1) + longint'(d) - 1 + longint'(off);
      lo = first_day_number(YEAR_FLOOR + YEAR_SHIFT, 1);
      hi = first_day_number(YEAR_CEIL + YEAR_SHIFT, 12) + 30;
      r.range_error = 1'b0;
      if (z < lo) begin
        z = lo;
        r.range_error = 1'b1;
      end else if (z > hi) begin
        z = hi;
        r.range_error = 1'b1;
      end
      era = z / ERA_DAYS;
      doe = z - era * ERA_DAYS;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      mm  = (mp < 10) ? mp + 3 : mp - 9;
      ry  = yoe + era * 400 + ((mm <= 2) ? 1 : 0) - YEAR_SHIFT;
      r.year  = 14'(ry);
      r.month = 4'(mm);
      r.day   = 5'(doy - (153 * mp + 2) / 5 + 1);
      return r;
    endfunction

    function void note_input(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                             logic signed [20:0] off);
      pending_dates.push_back(predict_date(y, m, d, off));
    endfunction

    function void check_result(date_result_t got);
      date_result_t want;
      if (pending_dates.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: %0d-%0d-%0d range_error %0b",
                   got.year, got.month, got.day, got.range_error);
        return;
      end
      want = pending_dates.pop_front();
      if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
          got.range_error !== want.range_error) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %0d-%0d-%0d range_error %0b, got %0d-%0d-%0d range_error %0b",
                   want.year, want.month, want.day, want.range_error,
                   got.year, got.month, got.day, got.range_error);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [13:0]        in_year;
  logic [3:0]         in_month;
  logic [4:0]         in_day;
  logic signed [20:0] in_day_offset;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [13:0]        out_result_year;
  logic [3:0]         out_result_month;
  logic [4:0]         out_result_day;
  logic               out_range_error;

  date_scoreboard board = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  int  sent_count;
  logic hold_off = 1'b0;

  gregorian_date_add_days_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_year          (in_year),
    .in_month         (in_month),
    .in_day           (in_day),
    .in_day_offset    (in_day_offset),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_year  (out_result_year),
    .out_result_month (out_result_month),
    .out_result_day   (out_result_day),
    .out_range_error  (out_range_error)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result({out_result_year, out_result_month, out_result_day,
                          out_range_error});
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // hold the result side off long enough that the pipeline fills and stalls input
  initial begin
    while (sent_count < 200) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_date(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d,
                           input logic signed [20:0] off);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_year       <= y;
    in_month      <= m;
    in_day        <= d;
    in_day_offset <= off;
    do @(posedge clk); while (in_stall);
    board.note_input(y, m, d, off);
    sent_count++;
  endtask

  function automatic logic signed [20:0] pick_offset();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4)
      return 21'($urandom_range(800) - 400);
    else if (sel < 7)
      return 21'($urandom_range(80000) - 40000);
    else
      return 21'($urandom);
  endfunction

  task automatic send_random();
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    y = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(9999, 1600));
    m = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(12, 1));
    d = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(31, 1));
    send_date(y, m, d, pick_offset());
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_year       = '0;
    in_month      = '0;
    in_day        = '0;
    in_day_offset = '0;
    send_idle_pct = 29;
    recv_idle_pct = 87;
    sent_count    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_date(14'd1600, 4'd1, 5'd1, 21'sd0);
    send_date(14'd9999, 4'd12, 5'd31, 21'sd0);
    send_date(14'd1600, 4'd1, 5'd1, -21'sd1);
    send_date(14'd9999, 4'd12, 5'd31, 21'sd1);
    send_date(14'd2000, 4'd2, 5'd28, 21'sd1);
    send_date(14'd2000, 4'd2, 5'd29, 21'sd1);
    send_date(14'd1900, 4'd2, 5'd28, 21'sd1);
    send_date(14'd2000, 4'd3, 5'd1, -21'sd1);
    send_date(14'd2023, 4'd2, 5'd31, 21'sd0);
    send_date(14'd2023, 4'd0, 5'd15, 21'sd0);
    send_date(14'd2023, 4'd13, 5'd15, 21'sd0);
    send_date(14'd2023, 4'd14, 5'd10, 21'sd0);
    send_date(14'd2023, 4'd15, 5'd31, 21'sd0);
    send_date(14'd2023, 4'd3, 5'd0, 21'sd0);
    send_date(14'd2024, 4'd1, 5'd0, 21'sd0);
    send_date(14'd0, 4'd0, 5'd0, 21'sd0);
    send_date(14'd16383, 4'd15, 5'd31, 21'sd0);
    send_date(14'd0, 4'd1, 5'd1, 21'sd1048575);
    send_date(14'd16383, 4'd12, 5'd31, -21'sd1048575);
    send_date(14'd5000, 4'd6, 5'd15, 21'sd1048575);
    send_date(14'd5000, 4'd6, 5'd15, -21'sd1048575);
    send_date(14'd5000, 4'd6, 5'd15, 21'h100000);
    send_date(14'd1601, 4'd1, 5'd1, -21'sd366);
    send_date(14'd9998, 4'd12, 5'd31, 21'sd365);

    repeat (420) send_random();
    send_idle_pct = 87;
    recv_idle_pct = 29;
    repeat (420) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (410) send_random();
    in_valid <= 1'b0;

    while (board.pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_dates.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
